// File: sv/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dqep_pkg.sv
// Package with codes, field widths and control structs of the deque unit.
`default_nettype none

package dqep_pkg;

  // Field widths of the stream words
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 7;
  localparam int unsigned IN_W     = 40;   // 35 payload bits padded to bytes
  localparam int unsigned OUT_W    = 112;  // 106 payload bits padded to bytes

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PURGE      = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;     // capture the accepted word
    logic exec;         // push, pop, clear or no-op
    logic purge_start;  // reset the purge walk
    logic purge_step;   // one read/compact step of the walk
    logic purge_end;    // commit the kept count
    logic read_ends;    // read front and back, capture popped word
    logic load_out;     // load the result register
  } dqep_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic op_purge;     // latched request is a purge
    logic purge_done;   // walk finished, no write pending
    logic out_free;     // result register can take a word
  } dqep_stat_t;

endpackage

`default_nettype wire

// File: sv/deque_with_even_purge_unit.sv
// Top level of the ring-buffer deque with even-value purge.
//
//  Channel   Dir  Width  Contents
//  s_axis    in   40     func, data_in
//  m_axis    out  112    status, removed_value, front_value, back_value,
//                        occupancy, is_empty
//
// One request is in flight at a time. Push, pop, clear and unused codes pass
// through the EXEC, ENDS and RESULT states; a purge goes from EXEC through
// PURGE, walking the RAM read port one element per cycle and draining the
// last read, before ENDS and RESULT. The result register frees the input side;
// a stalled result holds the unit only when the next result is ready.
// Reset clears pointers and count; storage is not cleared, and the ends of an
// empty queue are masked to zero in the result.
`default_nettype none

`include "assert_macros.svh"

module deque_with_even_purge_unit
  import dqep_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,  // func[2:0], data_in[34:3], zero
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [OUT_W-1:0] m_axis_tdata   // status[1:0], removed_value[33:2],
                                               // front_value[65:34],
                                               // back_value[97:66],
                                               // occupancy[104:98],
                                               // is_empty[105], zero
);

  dqep_cmd_t  cmd;
  dqep_stat_t stat;

  // Result fields watched by the checks
  logic        res_empty;
  logic [63:0] res_ends;

  dqep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dqep_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tdata_i   (s_axis_tdata),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

  assign res_empty = m_axis_tdata[105];
  assign res_ends  = m_axis_tdata[97:34];

  // Checks
  `ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  `ASSERT_IMPLY(a_load_free, cmd.load_out, stat.out_free, "result loaded over unsent word")
  `ASSERT_IMPLY(a_purge_end, cmd.purge_end, stat.purge_done, "purge ended with walk pending")
  `ASSERT_IMPLY(a_empty_ends, m_axis_tvalid && res_empty, res_ends == '0, "ends nonzero when empty")

endmodule

`default_nettype wire

// File: sv/dqep_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module dqep_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_a_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  input  wire logic             re_b_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/dqep_ctrl.sv
// Controller state machine sequencing one request at a time.
`default_nettype none

module dqep_ctrl
  import dqep_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dqep_stat_t stat_i,
  output dqep_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_PURGE  = 3'd2;
  localparam logic [2:0] S_ENDS   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.op_purge) begin
          cmd_o.purge_start = 1'b1;
          state_d           = S_PURGE;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_ENDS;
        end
      end
      S_PURGE: begin
        cmd_o.purge_step = 1'b1;
        if (stat_i.purge_done) begin
          cmd_o.purge_end = 1'b1;
          state_d         = S_ENDS;
        end
      end
      S_ENDS: begin
        cmd_o.read_ends = 1'b1;
        state_d         = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/dqep_dp.sv
// Datapath: ring pointers, storage, purge walk and result register.
`default_nettype none

module dqep_dp
  import dqep_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IN_W-1:0]  in_tdata_i,
  output logic                  out_tvalid_o,
  input  wire logic             out_tready_i,
  output logic      [OUT_W-1:0] out_tdata_o,
  input  wire dqep_cmd_t        cmd_i,
  output dqep_stat_t            stat_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_X   = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(DEPTH - 1);

  // Ring position: base plus an offset below DEPTH, wrapped once
  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(ofs);
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[AW-1:0];
  endfunction

  logic [FUNC_W-1:0]   func_q;
  logic [VAL_W-1:0]    data_q;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic [CW-1:0]       kept_q, kept_d;
  logic                pend_q, pend_d;
  logic                pop_ok_q, pop_ok_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VAL_W-1:0]    removed_q;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [VAL_W-1:0]  wdata;
  logic              re_a, re_b;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic [VAL_W-1:0]  rdata_a, rdata_b;

  logic              full, empty, issue;
  logic [CW-1:0]     last_ofs;

  assign full     = (count_q == FULL_CNT);
  assign empty    = (count_q == '0);
  assign last_ofs = count_q - CW'(1);
  assign issue    = (rd_idx_q < count_q);

  assign stat_o.op_purge   = (func_q == FUNC_PURGE);
  assign stat_o.purge_done = !pend_q && (rd_idx_q == count_q);
  assign stat_o.out_free   = !out_tvalid_o || out_tready_i;

  // Request execution, purge walk and storage access
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    kept_d   = kept_q;
    pend_d   = pend_q;
    pop_ok_d = pop_ok_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = ring_at(head_q, kept_q);
    wdata    = rdata_a;
    re_a     = 1'b0;
    raddr_a  = head_q;
    re_b     = 1'b0;
    raddr_b  = ring_at(head_q, last_ofs);

    if (cmd_i.latch_in) begin
      status_d = ST_OK;
      pop_ok_d = 1'b0;
    end

    if (cmd_i.exec) begin
      unique case (func_q)
        FUNC_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            head_d  = (head_q == '0) ? HEAD_LAST : head_q - AW'(1);
            we      = 1'b1;
            waddr   = (head_q == '0) ? HEAD_LAST : head_q - AW'(1);
            wdata   = data_q;
            count_d = count_q + CW'(1);
          end
        end
        FUNC_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = ring_at(head_q, count_q);
            wdata   = data_q;
            count_d = count_q + CW'(1);
          end
        end
        FUNC_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            re_a     = 1'b1;
            raddr_a  = head_q;
            pop_ok_d = 1'b1;
            head_d   = (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
            count_d  = last_ofs;
          end
        end
        FUNC_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            re_a     = 1'b1;
            raddr_a  = ring_at(head_q, last_ofs);
            pop_ok_d = 1'b1;
            count_d  = last_ofs;
          end
        end
        FUNC_CLEAR: begin
          head_d  = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.purge_start) begin
      rd_idx_d = '0;
      kept_d   = '0;
      pend_d   = 1'b0;
    end

    // Walk: read one element per cycle, write back odd ones compacted
    if (cmd_i.purge_step) begin
      pend_d = issue;
      if (issue) begin
        re_a     = 1'b1;
        raddr_a  = ring_at(head_q, rd_idx_q);
        rd_idx_d = rd_idx_q + CW'(1);
      end
      if (pend_q && rdata_a[0]) begin
        we     = 1'b1;
        waddr  = ring_at(head_q, kept_q);
        wdata  = rdata_a;
        kept_d = kept_q + CW'(1);
      end
    end

    if (cmd_i.purge_end) begin
      count_d = kept_q;
    end

    if (cmd_i.read_ends) begin
      re_a    = 1'b1;
      raddr_a = head_q;
      re_b    = 1'b1;
      raddr_b = ring_at(head_q, last_ofs);
    end
  end

  dqep_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (re_a),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (re_b),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      rd_idx_q <= '0;
      kept_q   <= '0;
      pend_q   <= 1'b0;
      pop_ok_q <= 1'b0;
      status_q <= ST_OK;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      kept_q   <= kept_d;
      pend_q   <= pend_d;
      pop_ok_q <= pop_ok_d;
      status_q <= status_d;
    end
  end

  // Request payload and popped word
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= in_tdata_i[FUNC_W-1:0];
      data_q <= in_tdata_i[FUNC_W +: VAL_W];
    end
    if (cmd_i.read_ends) begin
      removed_q <= pop_ok_q ? rdata_a : '0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_tvalid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_tvalid_o <= 1'b1;
    end else if (out_tready_i) begin
      out_tvalid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_tdata_o <= {6'b0,
                      empty,
                      OCC_W'(count_q),
                      empty ? '0 : rdata_b,
                      empty ? '0 : rdata_a,
                      removed_q,
                      status_q};
    end
  end

endmodule

`default_nettype wire
